@@ rtl/modular_exponentiation_top_macros.svh @@
// ----------------------------------------------------------------------------
// Modular exponentiation assertion macros
// Shared concurrent assertion wrappers, clocked on the rising edge and
// disabled while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_TOP_MACROS_SVH
`define MODULAR_EXPONENTIATION_TOP_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define MEXP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define MEXP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

@@ rtl/mexp_pkg.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Default sizes and the command and status types between the controller
// and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mexp_pkg;

	localparam int unsigned EXP_BITS_DEF = 16;
	localparam int unsigned MOD_BITS_DEF = 16;

	// Operand selection for one modular multiply.
	typedef enum logic [1:0] {
		OP_REDUCE,
		OP_SQUARE,
		OP_MULTIPLY
	} mul_op_t;

	typedef struct packed {
		logic    load;
		logic    mul_start;
		mul_op_t mul_op;
		logic    idx_dec;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic exp_zero;
		logic mod_zero;
		logic cur_bit;
		logic idx_zero;
		logic mul_done;
	} dp_sts_t;

endpackage

@@ rtl/mexp_mulmod.sv @@
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Interleaved multiply and reduce: one bit of the multiplier per cycle,
// the partial residue doubled, reduced, the multiplicand added and reduced.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "modular_exponentiation_top_macros.svh"

module mexp_mulmod #(
	parameter int unsigned MOD_BITS = mexp_pkg::MOD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [MOD_BITS-1:0] a,
	input  logic [MOD_BITS-1:0] b,
	input  logic [MOD_BITS-1:0] m,
	output logic                done,
	output logic [MOD_BITS-1:0] result
);

	localparam int unsigned CNT_W = (MOD_BITS > 1) ? $clog2(MOD_BITS) : 1;

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [MOD_BITS-1:0] a_q;
	logic [MOD_BITS-1:0] b_q;
	logic [MOD_BITS-1:0] m_q;
	logic [MOD_BITS-1:0] r_q;

	logic [MOD_BITS:0]   m_ext;
	logic [MOD_BITS:0]   dbl;
	logic [MOD_BITS:0]   red1;
	logic [MOD_BITS:0]   sum;
	logic [MOD_BITS:0]   red2;
	logic [MOD_BITS-1:0] r_next;

	// The residue stays below the modulus, so each add stays below twice
	// the modulus and one conditional subtract reduces it.
	always_comb begin
		m_ext  = {1'b0, m_q};
		dbl    = {r_q, 1'b0};
		red1   = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
		sum    = {1'b0, red1[MOD_BITS-1:0]} + (a_q[MOD_BITS-1] ? {1'b0, b_q} : '0);
		red2   = (sum >= m_ext) ? (sum - m_ext) : sum;
		r_next = red2[MOD_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(MOD_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			m_q <= m;
			r_q <= '0;
		end else if (busy_q) begin
			a_q <= {a_q[MOD_BITS-2:0], 1'b0};
			r_q <= r_next;
		end
	end

	assign done   = done_q;
	assign result = r_q;

	`MEXP_ASSERT(a_residue_reduced, clk, arst_n, busy_q |-> (r_q < m_q), "residue not below modulus")
	`MEXP_ASSERT_NEVER(a_done_while_busy, clk, arst_n, done_q && busy_q, "done raised while busy")

endmodule

@@ rtl/mexp_dp.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation datapath
// Operand, accumulator and exponent registers, bit index, the shared
// multiplier and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mexp_dp #(
	parameter int unsigned EXP_BITS = mexp_pkg::EXP_BITS_DEF,
	parameter int unsigned MOD_BITS = mexp_pkg::MOD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mexp_pkg::dp_cmd_t   cmd,
	output mexp_pkg::dp_sts_t   sts,
	input  logic [MOD_BITS-1:0] base,
	input  logic [EXP_BITS-1:0] exponent,
	input  logic [MOD_BITS-1:0] modulus,
	output logic [MOD_BITS-1:0] power_result
);

	localparam int unsigned IDX_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

	logic [MOD_BITS-1:0] base_q;
	logic [EXP_BITS-1:0] exp_q;
	logic [MOD_BITS-1:0] mod_q;
	logic [MOD_BITS-1:0] acc_q;
	logic [IDX_W-1:0]    idx_q;
	mexp_pkg::mul_op_t   op_q;
	logic [MOD_BITS-1:0] res_q;

	logic [MOD_BITS-1:0] mul_a;
	logic [MOD_BITS-1:0] mul_b;
	logic                mul_done;
	logic [MOD_BITS-1:0] mul_res;

	always_comb begin
		unique case (cmd.mul_op)
			mexp_pkg::OP_REDUCE: begin
				mul_a = base_q;
				mul_b = MOD_BITS'(1);
			end
			mexp_pkg::OP_SQUARE: begin
				mul_a = acc_q;
				mul_b = acc_q;
			end
			mexp_pkg::OP_MULTIPLY: begin
				mul_a = acc_q;
				mul_b = base_q;
			end
			default: begin
				mul_a = acc_q;
				mul_b = acc_q;
			end
		endcase
	end

	mexp_mulmod #(
		.MOD_BITS(MOD_BITS)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.m      (mod_q),
		.done   (mul_done),
		.result (mul_res)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q <= base;
			exp_q  <= exponent;
			mod_q  <= modulus;
			acc_q  <= MOD_BITS'(1);
			idx_q  <= IDX_W'(EXP_BITS - 1);
		end else begin
			if (cmd.idx_dec) begin
				idx_q <= idx_q - 1'b1;
			end
			if (mul_done) begin
				if (op_q == mexp_pkg::OP_REDUCE) begin
					base_q <= mul_res;
				end else begin
					acc_q <= mul_res;
				end
			end
		end
		if (cmd.mul_start) begin
			op_q <= cmd.mul_op;
		end
		if (cmd.out_load) begin
			if (exp_q == '0) begin
				res_q <= MOD_BITS'(1);
			end else if (mod_q == '0) begin
				res_q <= '0;
			end else begin
				res_q <= acc_q;
			end
		end
	end

	assign sts.exp_zero = (exp_q == '0);
	assign sts.mod_zero = (mod_q == '0);
	assign sts.cur_bit  = exp_q[idx_q];
	assign sts.idx_zero = (idx_q == '0);
	assign sts.mul_done = mul_done;

	assign power_result = res_q;

endmodule

@@ rtl/mexp_ctrl.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation controller
// Sequences base reduction, the leading-zero skip and the square and
// multiply steps, and owns both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "modular_exponentiation_top_macros.svh"

module mexp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output mexp_pkg::dp_cmd_t cmd,
	input  mexp_pkg::dp_sts_t sts
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_RED_GO,
		S_RED_WAIT,
		S_SCAN,
		S_SQ_GO,
		S_SQ_WAIT,
		S_MUL_GO,
		S_MUL_WAIT,
		S_NEXT,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;

	always_comb begin
		cmd.load      = (state_q == S_IDLE) && req_valid;
		cmd.mul_start = 1'b0;
		cmd.mul_op    = mexp_pkg::OP_SQUARE;
		cmd.idx_dec   = 1'b0;
		cmd.out_load  = 1'b0;
		unique case (state_q)
			S_RED_GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_op    = mexp_pkg::OP_REDUCE;
			end
			S_SQ_GO: begin
				cmd.mul_start = 1'b1;
			end
			S_MUL_GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_op    = mexp_pkg::OP_MULTIPLY;
			end
			S_SCAN: begin
				cmd.idx_dec = !sts.cur_bit;
			end
			S_NEXT: begin
				cmd.idx_dec = !sts.idx_zero;
			end
			S_FINISH: begin
				cmd.out_load = !rsp_valid_q || rsp_ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (sts.exp_zero || sts.mod_zero) begin
						state_q <= S_FINISH;
					end else begin
						state_q <= S_RED_GO;
					end
				end
				S_RED_GO: begin
					state_q <= S_RED_WAIT;
				end
				S_RED_WAIT: begin
					if (sts.mul_done) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (sts.cur_bit) begin
						state_q <= S_SQ_GO;
					end
				end
				S_SQ_GO: begin
					state_q <= S_SQ_WAIT;
				end
				S_SQ_WAIT: begin
					if (sts.mul_done) begin
						state_q <= sts.cur_bit ? S_MUL_GO : S_NEXT;
					end
				end
				S_MUL_GO: begin
					state_q <= S_MUL_WAIT;
				end
				S_MUL_WAIT: begin
					if (sts.mul_done) begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					state_q <= sts.idx_zero ? S_FINISH : S_SQ_GO;
				end
				S_FINISH: begin
					if (cmd.out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	`MEXP_ASSERT(a_done_in_wait, clk, arst_n, sts.mul_done |-> (state_q == S_RED_WAIT || state_q == S_SQ_WAIT || state_q == S_MUL_WAIT), "multiply done outside a wait state")
	`MEXP_ASSERT(a_start_not_done, clk, arst_n, cmd.mul_start |=> !sts.mul_done, "multiply finished in one cycle")
	`MEXP_ASSERT(a_load_room, clk, arst_n, cmd.out_load |-> (!rsp_valid_q || rsp_ready), "result overwritten before it was taken")
	`MEXP_ASSERT(a_trivial_fast, clk, arst_n, (state_q == S_CHECK && sts.exp_zero) |=> (state_q == S_FINISH), "zero exponent did not finish at once")

endmodule

@@ rtl/modular_exponentiation_top.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation top level
// Left to right binary square and multiply over a shared bit-serial
// modular multiplier, with a controller and a datapath.
// ----------------------------------------------------------------------------
// Computes base to the power exponent modulo modulus, one item at a time.
// An item is taken on req_valid and req_ready, and its result is offered
// on rsp_valid with power_result. A zero exponent returns 1 (not reduced),
// and a zero modulus with a nonzero exponent returns 0; both go straight
// to the result with no multiply. Otherwise the base is first reduced by
// one modular multiply, the exponent is scanned down to its highest set
// bit at one bit per cycle, and every bit from there down costs one
// squaring, one more multiply when the bit is set, and a step to the next
// bit. Each modular multiply runs on the single bit-serial multiplier. The
// finished result sits in an output register, so the next item is
// accepted while it waits to be taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modular_exponentiation_top #(
	parameter int unsigned EXP_BITS = mexp_pkg::EXP_BITS_DEF,
	parameter int unsigned MOD_BITS = mexp_pkg::MOD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic [MOD_BITS-1:0] base,
	input  logic [EXP_BITS-1:0] exponent,
	input  logic [MOD_BITS-1:0] modulus,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic [MOD_BITS-1:0] power_result
);

	mexp_pkg::dp_cmd_t cmd;
	mexp_pkg::dp_sts_t sts;

	// Sequencing and both handshakes live in the controller.
	mexp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Operands, accumulator, multiplier and the result register.
	mexp_dp #(
		.EXP_BITS(EXP_BITS),
		.MOD_BITS(MOD_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.base         (base),
		.exponent     (exponent),
		.modulus      (modulus),
		.power_result (power_result)
	);

endmodule

@@ verif/tb_modular_exponentiation_top.sv @@
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Drives base, exponent and modulus items through the valid/ready request
// channel and checks every power_result against a hand-typed value or a
// behavioral square and multiply predictor. A directed table covers the
// corner cases, then about a thousand random items follow with bursty
// requests and a stalling receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_modular_exponentiation_top;

	localparam int unsigned EXP_W = mexp_pkg::EXP_BITS_DEF;
	localparam int unsigned MOD_W = mexp_pkg::MOD_BITS_DEF;

	localparam int N_RANDOM     = 1000;
	localparam int DRAIN_CYCLES = 40;
	// Allow several times the slowest item plus the longest receiver stall
	// and sender gap.
	localparam int STALL_LIMIT  = 4000;

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_ready;
	logic [MOD_W-1:0] base;
	logic [EXP_W-1:0] exponent;
	logic [MOD_W-1:0] modulus;
	logic             rsp_valid;
	logic             rsp_ready;
	logic [MOD_W-1:0] power_result;

	// One row of the directed table. When known is set, power holds the
	// result typed in by hand; otherwise the predictor supplies it.
	typedef struct packed {
		logic [MOD_W-1:0] base;
		logic [EXP_W-1:0] exponent;
		logic [MOD_W-1:0] modulus;
		logic             known;
		logic [MOD_W-1:0] power;
	} stim_row_t;

	// An accepted item together with the result it must produce.
	typedef struct packed {
		logic [MOD_W-1:0] base;
		logic [EXP_W-1:0] exponent;
		logic [MOD_W-1:0] modulus;
		logic [MOD_W-1:0] power;
	} power_due_t;

	localparam int N_DIRECTED = 24;

	stim_row_t directed_rows [N_DIRECTED] = '{
		// Zero exponent returns 1 without reduction, whatever the modulus.
		'{16'd0,     16'd0,     16'd1,     1'b1, 16'd1},
		'{16'd65535, 16'd0,     16'd65535, 1'b1, 16'd1},
		'{16'd1234,  16'd0,     16'd0,     1'b1, 16'd1},
		// Zero modulus with a nonzero exponent returns 0.
		'{16'd7,     16'd5,     16'd0,     1'b1, 16'd0},
		'{16'd65535, 16'd65535, 16'd0,     1'b1, 16'd0},
		// Modulus one with a nonzero exponent reduces everything to 0.
		'{16'd65535, 16'd65535, 16'd1,     1'b1, 16'd0},
		'{16'd3,     16'd1,     16'd1,     1'b1, 16'd0},
		// Zero and one as the base.
		'{16'd0,     16'd1,     16'd65535, 1'b1, 16'd0},
		'{16'd0,     16'd65535, 16'd65535, 1'b1, 16'd0},
		'{16'd1,     16'd65535, 16'd65535, 1'b1, 16'd1},
		// Exponent one with the base below, above and at the modulus, then two more known cases.
		'{16'd5,     16'd1,     16'd7,     1'b1, 16'd5},
		'{16'd12,    16'd1,     16'd7,     1'b1, 16'd5},
		'{16'd65535, 16'd1,     16'd65535, 1'b1, 16'd0},
		'{16'd65535, 16'd65535, 16'd65535, 1'b1, 16'd0},
		'{16'd2,     16'd2,     16'd65535, 1'b1, 16'd4},
		// Everything else comes from the predictor.
		'{16'd2,     16'd16,    16'd65535, 1'b0, 16'd0},
		'{16'd65535, 16'd65535, 16'd65534, 1'b0, 16'd0},
		'{16'd65534, 16'd65535, 16'd65535, 1'b0, 16'd0},
		'{16'd2,     16'h8000,  16'd65521, 1'b0, 16'd0},
		'{16'd3,     16'd65535, 16'd2,     1'b0, 16'd0},
		'{16'hAAAA,  16'h5555,  16'h8001,  1'b0, 16'd0},
		'{16'h5555,  16'hAAAA,  16'h7FFF,  1'b0, 16'd0},
		'{16'd65535, 16'd2,     16'd65534, 1'b0, 16'd0},
		'{16'd65535, 16'h8000,  16'd40000, 1'b0, 16'd0}
	};

	power_due_t power_due [$];

	int errors;
	int n_checked;
	int n_sent;
	int n_zero_exp;
	int n_mod_one;
	int n_full_exp;
	int burst_left;

	modular_exponentiation_top #(
		.EXP_BITS(EXP_W),
		.MOD_BITS(MOD_W)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.base        (base),
		.exponent    (exponent),
		.modulus     (modulus),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.power_result(power_result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Square and multiply from the highest set exponent bit down, with the
	// running value starting at 1 and the base reduced before the scan.
	function automatic logic [MOD_W-1:0] modpow_expected(input logic [MOD_W-1:0] b,
			input logic [EXP_W-1:0] e, input logic [MOD_W-1:0] m);
		logic [2*MOD_W-1:0] acc;
		logic [2*MOD_W-1:0] b_red;
		int                 top;
		if (e == '0) begin
			return MOD_W'(1);
		end
		if (m == '0) begin
			return '0;
		end
		top = -1;
		for (int i = 0; i < EXP_W; i++) begin
			if (e[i]) begin
				top = i;
			end
		end
		b_red = (2*MOD_W)'(b) % (2*MOD_W)'(m);
		acc = 1;
		for (int i = top; i >= 0; i--) begin
			acc = (acc * acc) % (2*MOD_W)'(m);
			if (e[i]) begin
				acc = (acc * b_red) % (2*MOD_W)'(m);
			end
		end
		return acc[MOD_W-1:0];
	endfunction

	// Present one item, hold it until it is taken, record what it must
	// produce, then decide whether the sender keeps going or pauses. Must
	// be called at a rising edge.
	task automatic send_item(input logic [MOD_W-1:0] b, input logic [EXP_W-1:0] e,
			input logic [MOD_W-1:0] m, input logic [MOD_W-1:0] pw);
		int gap;
		req_valid <= 1'b1;
		base      <= b;
		exponent  <= e;
		modulus   <= m;
		do @(posedge clk); while (!req_ready);
		power_due.push_back('{b, e, m, pw});
		n_sent++;
		if (e == '0) n_zero_exp++;
		if (m == MOD_W'(1)) n_mod_one++;
		if (e[EXP_W-1]) n_full_exp++;

		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom % 4 == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
			gap = ($urandom % 3 == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				// Idle with junk on the payload so that it is never trusted
				// while valid is low.
				req_valid <= 1'b0;
				base      <= MOD_W'($urandom);
				exponent  <= EXP_W'($urandom);
				modulus   <= MOD_W'($urandom);
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Receiver: ready steps through a 32-bit mask that is redrawn each time
	// it runs out. Some masks are all ones, the rest leave at least one slot.
	logic [31:0] ready_mask;
	int          mask_pos;

	always @(posedge clk) begin
		power_due_t head;
		if (!arst_n) begin
			rsp_ready  <= 1'b0;
			ready_mask <= '1;
			mask_pos   <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (power_due.size() == 0) begin
					$display("%0t: unexpected result power_result=%0d, nothing outstanding",
						$time, power_result);
					errors++;
				end else begin
					head = power_due.pop_front();
					n_checked++;
					if (power_result !== head.power) begin
						$display("%0t: MISMATCH power_result (base=%0d exponent=%0d modulus=%0d): expected %0d, actual %0d",
							$time, head.base, head.exponent, head.modulus,
							head.power, power_result);
						errors++;
					end
				end
			end

			rsp_ready <= ready_mask[mask_pos];
			if (mask_pos == 31) begin
				mask_pos <= 0;
				case ($urandom % 4)
					0: ready_mask <= '1;
					1: ready_mask <= $urandom | 32'h1;
					2: ready_mask <= ($urandom & $urandom) | 32'h1;
					default: ready_mask <= 32'h5555_5555;
				endcase
			end else begin
				mask_pos <= mask_pos + 1;
			end
		end
	end

	// Watchdog: ends the run when no item moves on either channel for too
	// long.
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("%0t: no item accepted for %0d cycles, %0d results outstanding",
			$time, STALL_LIMIT, power_due.size());
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		logic [MOD_W-1:0] b;
		logic [EXP_W-1:0] e;
		logic [MOD_W-1:0] m;
		logic [MOD_W-1:0] pw;

		errors     = 0;
		n_checked  = 0;
		n_sent     = 0;
		n_zero_exp = 0;
		n_mod_one  = 0;
		n_full_exp = 0;
		burst_left = 3;

		arst_n    = 1'b0;
		req_valid = 1'b0;
		base      = '0;
		exponent  = '0;
		modulus   = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		for (int r = 0; r < N_DIRECTED; r++) begin
			if (directed_rows[r].known) begin
				pw = directed_rows[r].power;
			end else begin
				pw = modpow_expected(directed_rows[r].base, directed_rows[r].exponent,
					directed_rows[r].modulus);
			end
			send_item(directed_rows[r].base, directed_rows[r].exponent,
				directed_rows[r].modulus, pw);
		end

		// Random items. Exponents lean toward full width so the long scans
		// get exercised, with zero, tiny and all-ones exponents mixed in.
		for (int n = 0; n < N_RANDOM; n++) begin
			case ($urandom % 10)
				0:       m = MOD_W'(1);
				1:       m = '1;
				2:       m = MOD_W'($urandom_range(2, 16));
				3:       m = MOD_W'(1) << $urandom_range(1, MOD_W - 1);
				default: m = MOD_W'($urandom_range(1, (1 << MOD_W) - 1));
			endcase
			case ($urandom % 10)
				0:       e = '0;
				1, 2:    e = EXP_W'($urandom_range(1, 15));
				3:       e = '1;
				4:       e = EXP_W'($urandom) | (EXP_W'(1) << (EXP_W - 1));
				default: e = EXP_W'($urandom);
			endcase
			case ($urandom % 8)
				0:       b = '0;
				1:       b = MOD_W'(1);
				2:       b = '1;
				3:       b = m - MOD_W'(1);
				default: b = MOD_W'($urandom);
			endcase
			send_item(b, e, m, modpow_expected(b, e, m));
		end

		req_valid <= 1'b0;
		while (power_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d items (%0d directed, %0d random), checked %0d results.",
			n_sent, N_DIRECTED, N_RANDOM, n_checked);
		$display("Zero exponent: %0d, modulus one: %0d, exponent top bit set: %0d.",
			n_zero_exp, n_mod_one, n_full_exp);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/mexp_pkg.sv
rtl/mexp_mulmod.sv
rtl/mexp_dp.sv
rtl/mexp_ctrl.sv
rtl/modular_exponentiation_top.sv
verif/tb_modular_exponentiation_top.sv
